@@ src/ssnf_pkg.sv @@
// Shared types and constants for the seven-segment number formatter.
`timescale 1ns / 1ps

package ssnf_pkg;

   // Widths fixed by the request and response fields.
   localparam int NUMBER_W = 28;
   localparam int TIME_W   = 7;
   localparam int COUNT_W  = 4;
   localparam int POS_W    = 3;
   localparam int SYM_W    = 4;
   localparam int LIMIT_W  = 27;

   // Symbol codes beyond the decimal digits.
   localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;

   // Time mode field limits.
   localparam logic [TIME_W-1:0] HOURS_MAX   = 7'd23;
   localparam logic [TIME_W-1:0] MINUTES_MAX = 7'd59;

   // Largest positive magnitude shown with n digits, indexed by n - 1.
   localparam logic [LIMIT_W-1:0] POS_LIMIT_TABLE [0:7] = '{
      27'd9, 27'd99, 27'd999, 27'd9999, 27'd99999,
      27'd999999, 27'd9999999, 27'd99999999
   };

   // Largest negative magnitude shown with n digits, indexed by n - 1.
   localparam logic [LIMIT_W-1:0] NEG_LIMIT_TABLE [0:7] = '{
      27'd0, 27'd9, 27'd99, 27'd999, 27'd9999,
      27'd99999, 27'd999999, 27'd9999999
   };

   // Quotient and remainder of the shared divide-by-ten unit.
   typedef struct packed {
      logic [NUMBER_W-1:0] quot;
      logic [SYM_W-1:0]    rem;
   } div_result_type;

   // One digit write toward the display.
   typedef struct packed {
      logic [POS_W-1:0] digit_position;
      logic [SYM_W-1:0] symbol;
      logic             dot;
      logic             last;
   } rsp_type;

endpackage

@@ src/ssnf_div10.sv @@
// Divide-by-ten unit shared by all digit extraction steps.
`timescale 1ns / 1ps

module ssnf_div10
   import ssnf_pkg::*;
(
   input  logic [NUMBER_W-1:0] dividend,
   output div_result_type      result
);

   // Reciprocal of ten scaled by 2^31; exact for all dividends below 2^30.
   localparam int                 SHIFT = 31;
   localparam int                 PROD_W = 2 * NUMBER_W;
   localparam logic [NUMBER_W-1:0] RECIP = 28'd214748365;

   logic [PROD_W-1:0]   product;
   logic [NUMBER_W-1:0] quot;
   logic [NUMBER_W-1:0] times_ten;
   logic [NUMBER_W-1:0] rem_full;

   // Quotient from the reciprocal product.
   assign product = PROD_W'(dividend) * PROD_W'(RECIP);
   assign quot    = NUMBER_W'(product[PROD_W-1:SHIFT]);

   // Remainder by subtracting ten times the quotient.
   assign times_ten = {quot[NUMBER_W-4:0], 3'b000} + {quot[NUMBER_W-2:0], 1'b0};
   assign rem_full  = dividend - times_ten;

   assign result.quot = quot;
   assign result.rem  = rem_full[SYM_W-1:0];

endmodule

@@ src/ssnf_ctrl.sv @@
// Sequencer that steps the divide unit and issues one digit write per cycle.
`timescale 1ns / 1ps

module ssnf_ctrl
   import ssnf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [NUMBER_W-1:0] req_number,
   input  logic [TIME_W-1:0]   req_hours,
   input  logic [TIME_W-1:0]   req_minutes,
   input  logic [COUNT_W-1:0]  digit_count,
   output logic [NUMBER_W-1:0] div_operand,
   input  div_result_type      div_result,
   output logic                rsp_strobe,
   output rsp_type             rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIGITS,
      ST_SIGN,
      ST_DASH,
      ST_TIME
   } state_type;

   state_type           state_ff, state_in;
   logic [NUMBER_W-1:0] mag_ff, mag_in;
   logic [TIME_W-1:0]   hours_ff, hours_in;
   logic [TIME_W-1:0]   minutes_ff, minutes_in;
   logic                hbad_ff, hbad_in;
   logic                mbad_ff, mbad_in;
   logic                neg_ff, neg_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                strobe_ff, strobe_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic [NUMBER_W-1:0] raw;
   logic [COUNT_W-1:0]  pos_next;
   logic [POS_W-1:0]    limit_idx;
   logic                out_of_range;
   logic                stop;
   logic                sign_room;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign raw    = req_number;

   // Time mode feeds hours then minutes; integer mode feeds the magnitude.
   always_comb begin
      if (state_ff == ST_TIME) begin
         div_operand = pos_ff[1] ? NUMBER_W'(hours_ff) : NUMBER_W'(minutes_ff);
      end else begin
         div_operand = mag_ff;
      end
   end

   // Range check against the limits for the latched digit count.
   assign limit_idx    = POS_W'(count_ff - 4'd1);
   assign out_of_range = neg_ff ? (mag_ff > NUMBER_W'(NEG_LIMIT_TABLE[limit_idx]))
                                : (mag_ff > NUMBER_W'(POS_LIMIT_TABLE[limit_idx]));

   // Digit loop exit and room for a sign to the left.
   assign pos_next  = {1'b0, pos_ff} + 4'd1;
   assign stop      = (div_result.quot == '0) || (pos_next >= count_ff);
   assign sign_room = neg_ff && (pos_next < count_ff);

   // Next state and next response.
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      hbad_in    = hbad_ff;
      mbad_in    = mbad_ff;
      neg_in     = neg_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in     = raw[NUMBER_W-1];
               mag_in     = raw[NUMBER_W-1] ? (~raw + 28'd1) : raw;
               hours_in   = req_hours;
               minutes_in = req_minutes;
               hbad_in    = req_hours > HOURS_MAX;
               mbad_in    = req_minutes > MINUTES_MAX;
               count_in   = digit_count;
               if (req_operation) begin
                  pos_in   = 3'd3;
                  state_in = ST_TIME;
               end else begin
                  pos_in   = 3'd0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = out_of_range ? ST_DASH : ST_DIGITS;
         end
         ST_DIGITS: begin
            strobe_in             = 1'b1;
            rsp_in.digit_position = pos_ff;
            rsp_in.symbol         = div_result.rem;
            rsp_in.dot            = 1'b0;
            rsp_in.last           = stop && !sign_room;
            mag_in                = div_result.quot;
            if (stop && !sign_room) begin
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 3'd1;
               if (stop) begin
                  state_in = ST_SIGN;
               end
            end
         end
         ST_SIGN: begin
            strobe_in             = 1'b1;
            rsp_in.digit_position = pos_ff;
            rsp_in.symbol         = SYM_MINUS;
            rsp_in.dot            = 1'b0;
            rsp_in.last           = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_DASH: begin
            strobe_in             = 1'b1;
            rsp_in.digit_position = pos_ff;
            rsp_in.symbol         = SYM_MINUS;
            rsp_in.dot            = 1'b0;
            rsp_in.last           = (pos_next == count_ff);
            if (pos_next == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         ST_TIME: begin
            // Odd positions take the tens, even positions the units.
            strobe_in             = 1'b1;
            rsp_in.digit_position = pos_ff;
            if (pos_ff[1] ? hbad_ff : mbad_ff) begin
               rsp_in.symbol = SYM_MINUS;
            end else if (pos_ff[0]) begin
               rsp_in.symbol = div_result.quot[SYM_W-1:0];
            end else begin
               rsp_in.symbol = div_result.rem;
            end
            rsp_in.dot  = (pos_ff == 3'd2);
            rsp_in.last = (pos_ff == 3'd0);
            if (pos_ff == 3'd0) begin
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff - 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      mag_ff     <= mag_in;
      hours_ff   <= hours_in;
      minutes_ff <= minutes_in;
      hbad_ff    <= hbad_in;
      mbad_ff    <= mbad_in;
      neg_ff     <= neg_in;
      count_ff   <= count_in;
      pos_ff     <= pos_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // A write only follows a cycle in which the sequencer was working.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("write issued without a request in progress");

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // The final write of a request leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset) (rsp_strobe && rsp.last) |-> !busy)
      else $error("sequencer still busy after final write");

   // A write that is not final means more writes are on the way.
   assert property (@(posedge clock) disable iff (reset) (rsp_strobe && !rsp.last) |-> busy)
      else $error("request ended without a final write");

   // Symbols never exceed the minus sign code.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> (rsp.symbol <= SYM_MINUS))
      else $error("symbol code out of range");

endmodule

@@ src/seven_segment_number_formatter.sv @@
// Top level of the seven-segment number formatter: digit count register and units.
`timescale 1ns / 1ps
// Time requests write from the state entered on start; integer requests pass a range
// check state first. Integer requests make at most 8 writes, time requests 4. The shared
// divide-by-ten unit makes one digit per cycle while digits are being written.
// The next request is taken while the final write is on the outputs; writes cannot stall.
// Synchronous reset returns to idle with no write pending and the digit count at 4.

module seven_segment_number_formatter
   import ssnf_pkg::*;
#(
   parameter int MAX_DIGITS = 8
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_operation,
   input  logic signed [NUMBER_W-1:0] req_number,
   input  logic [TIME_W-1:0]          req_hours,
   input  logic [TIME_W-1:0]          req_minutes,
   input  logic                       csr_write_en,
   input  logic [COUNT_W-1:0]         csr_write_data,
   output logic                       rsp_strobe,
   output logic [POS_W-1:0]           rsp_digit_position,
   output logic [SYM_W-1:0]           rsp_symbol,
   output logic                       rsp_dot,
   output logic                       rsp_last
);

   localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_DIGITS);
   localparam logic [COUNT_W-1:0] RESET_COUNT = 4'd4;

   logic [COUNT_W-1:0]  digit_count_ff;
   logic [COUNT_W-1:0]  digit_count_in;
   logic [COUNT_W-1:0]  eff_count;
   logic [NUMBER_W-1:0] div_operand;
   div_result_type      div_result;
   rsp_type             rsp;

   // Digit count register.
   assign digit_count_in = csr_write_en ? csr_write_data : digit_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= RESET_COUNT;
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   // Clamp the digit count into one to the fitted maximum.
   always_comb begin
      if (digit_count_ff == '0) begin
         eff_count = 4'd1;
      end else if (digit_count_ff > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end else begin
         eff_count = digit_count_ff;
      end
   end

   ssnf_div10 u_div10 (
      .dividend (div_operand),
      .result   (div_result)
   );

   ssnf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_number    (req_number),
      .req_hours     (req_hours),
      .req_minutes   (req_minutes),
      .digit_count   (eff_count),
      .div_operand   (div_operand),
      .div_result    (div_result),
      .rsp_strobe    (rsp_strobe),
      .rsp           (rsp)
   );

   assign rsp_digit_position = rsp.digit_position;
   assign rsp_symbol         = rsp.symbol;
   assign rsp_dot            = rsp.dot;
   assign rsp_last           = rsp.last;

endmodule

@@ verif/seven_segment_number_formatter_tb.sv @@
// Self-checking testbench for the seven-segment number formatter.
`timescale 1ns / 1ps

module seven_segment_number_formatter_tb
   import ssnf_pkg::*;
();

   localparam int DISPLAY_DIGITS = 8;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 32;
   localparam int NUM_DIRECTED   = 25;

   typedef enum logic {
      OP_INTEGER = 1'b0,
      OP_TIME    = 1'b1
   } op_mode_type;

   // One directed request. When typed_writes is nonzero, typed_syms holds the
   // expected symbol at each position in nibble p, so the hex reads like the display.
   typedef struct packed {
      logic [COUNT_W-1:0]         count;
      op_mode_type                op;
      logic signed [NUMBER_W-1:0] number;
      logic [TIME_W-1:0]          hours;
      logic [TIME_W-1:0]          minutes;
      logic [3:0]                 typed_writes;
      logic [31:0]                typed_syms;
   } dir_row_type;

   localparam dir_row_type DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
      '{4'd4,  OP_INTEGER, 28'sd0,        7'd0,   7'd0,   4'd1, 32'h0},
      '{4'd4,  OP_INTEGER, 28'sd9999,     7'd0,   7'd0,   4'd4, 32'h9999},
      '{4'd4,  OP_INTEGER, 28'sd10000,    7'd0,   7'd0,   4'd4, 32'hAAAA},
      '{4'd4,  OP_INTEGER, -28'sd999,     7'd0,   7'd0,   4'd4, 32'hA999},
      '{4'd4,  OP_INTEGER, -28'sd1000,    7'd0,   7'd0,   4'd4, 32'hAAAA},
      '{4'd4,  OP_INTEGER, -28'sd7,       7'd0,   7'd0,   4'd2, 32'hA7},
      '{4'd4,  OP_TIME,    28'sd0,        7'd23,  7'd59,  4'd4, 32'h2359},
      '{4'd4,  OP_TIME,    28'sd0,        7'd0,   7'd0,   4'd4, 32'h0000},
      '{4'd4,  OP_TIME,    28'sd0,        7'd24,  7'd59,  4'd4, 32'hAA59},
      '{4'd4,  OP_TIME,    28'sd0,        7'd23,  7'd60,  4'd4, 32'h23AA},
      '{4'd4,  OP_TIME,    28'sd0,        7'd127, 7'd127, 4'd4, 32'hAAAA},
      '{4'd1,  OP_INTEGER, 28'sd9,        7'd0,   7'd0,   4'd1, 32'h9},
      '{4'd1,  OP_INTEGER, 28'sd10,       7'd0,   7'd0,   4'd1, 32'hA},
      '{4'd1,  OP_INTEGER, -28'sd1,       7'd0,   7'd0,   4'd1, 32'hA},
      '{4'd1,  OP_TIME,    28'sd0,        7'd12,  7'd34,  4'd4, 32'h1234},
      '{4'd0,  OP_INTEGER, 28'sd5,        7'd0,   7'd0,   4'd1, 32'h5},
      '{4'd0,  OP_INTEGER, -28'sd3,       7'd0,   7'd0,   4'd1, 32'hA},
      '{4'd8,  OP_INTEGER, 28'sd99999999, 7'd0,   7'd0,   4'd8, 32'h99999999},
      '{4'd8,  OP_INTEGER, 28'sd100000000,7'd0,   7'd0,   4'd8, 32'hAAAAAAAA},
      '{4'd8,  OP_INTEGER, -28'sd9999999, 7'd0,   7'd0,   4'd8, 32'hA9999999},
      '{4'd8,  OP_INTEGER, -28'sd10000000,7'd0,   7'd0,   4'd8, 32'hAAAAAAAA},
      '{4'd8,  OP_INTEGER, 28'sh7FFFFFF,  7'd0,   7'd0,   4'd8, 32'hAAAAAAAA},
      '{4'd8,  OP_INTEGER, 28'sh8000000,  7'd0,   7'd0,   4'd8, 32'hAAAAAAAA},
      '{4'd15, OP_INTEGER, -28'sd1234,    7'd0,   7'd0,   4'd0, 32'h0},
      '{4'd9,  OP_INTEGER, 28'sd12345678, 7'd0,   7'd0,   4'd0, 32'h0}
   };

   // Digit count for each random phase; the first phase runs with no idle gaps.
   localparam logic [COUNT_W-1:0] PHASE_COUNTS [0:RANDOM_PHASES-1] = '{
      4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10
   };

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_operation;
   logic signed [NUMBER_W-1:0] req_number;
   logic [TIME_W-1:0]          req_hours;
   logic [TIME_W-1:0]          req_minutes;
   logic                       csr_write_en;
   logic [COUNT_W-1:0]         csr_write_data;
   logic                       rsp_strobe;
   logic [POS_W-1:0]           rsp_digit_position;
   logic [SYM_W-1:0]           rsp_symbol;
   logic                       rsp_dot;
   logic                       rsp_last;

   // Digit count as last written, and the digit writes still owed by the block.
   logic [COUNT_W-1:0] digit_count_shadow;
   rsp_type            writes_due [$];

   int mismatches;
   int writes_checked;
   int integer_requests;
   int time_requests;
   int count_writes;

   seven_segment_number_formatter #(
      .MAX_DIGITS(DISPLAY_DIGITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_number        (req_number),
      .req_hours         (req_hours),
      .req_minutes       (req_minutes),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_digit_position(rsp_digit_position),
      .rsp_symbol        (rsp_symbol),
      .rsp_dot           (rsp_dot),
      .rsp_last          (rsp_last)
   );

   // Clock generation.
   always #5 clock = ~clock;

   function automatic longint pow10(input int e);
      longint v;
      v = 1;
      for (int i = 0; i < e; i++) v = v * 10;
      return v;
   endfunction

   // Number of positions the integer mode really uses for a given register value.
   function automatic int visible_digits(input logic [COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > DISPLAY_DIGITS) return DISPLAY_DIGITS;
      return int'(count);
   endfunction

   function automatic void owe_write(input int pos, input logic [SYM_W-1:0] sym,
                                     input logic dot, input logic last);
      rsp_type w;
      w.digit_position = pos[POS_W-1:0];
      w.symbol         = sym;
      w.dot            = dot;
      w.last           = last;
      writes_due.push_back(w);
   endfunction

   // Works out the digit writes a request causes under the current digit count.
   function automatic void format_request(input op_mode_type op,
                                          input logic signed [NUMBER_W-1:0] number,
                                          input logic [TIME_W-1:0] hours,
                                          input logic [TIME_W-1:0] minutes);
      int     n;
      int     p;
      bit     neg;
      bit     done;
      bit     too_wide;
      longint mag;
      longint pow_lo;
      if (op == OP_TIME) begin
         owe_write(3, (hours > HOURS_MAX) ? SYM_MINUS : SYM_W'(hours / 10), 1'b0, 1'b0);
         owe_write(2, (hours > HOURS_MAX) ? SYM_MINUS : SYM_W'(hours % 10), 1'b1, 1'b0);
         owe_write(1, (minutes > MINUTES_MAX) ? SYM_MINUS : SYM_W'(minutes / 10),
                   1'b0, 1'b0);
         owe_write(0, (minutes > MINUTES_MAX) ? SYM_MINUS : SYM_W'(minutes % 10),
                   1'b0, 1'b1);
         return;
      end
      n      = visible_digits(digit_count_shadow);
      neg    = number[NUMBER_W-1];
      mag    = neg ? -longint'(number) : longint'(number);
      pow_lo = pow10(n - 1);
      too_wide = neg ? (mag > pow_lo - 1) : (mag > pow_lo * 10 - 1);
      if (too_wide) begin
         for (p = 0; p < n; p++) owe_write(p, SYM_MINUS, 1'b0, p == n - 1);
         return;
      end
      // Digits from the right, then the sign one place left of the top digit if it fits.
      p = 0;
      while (1) begin
         done = (mag / 10 == 0) || (p + 1 >= n);
         owe_write(p, SYM_W'(mag % 10), 1'b0, done && !(neg && p + 1 < n));
         mag = mag / 10;
         if (done) break;
         p++;
      end
      if (neg && p + 1 < n) owe_write(p + 1, SYM_MINUS, 1'b0, 1'b1);
   endfunction

   // Expectations typed into the directed table: nibble p is the symbol at position p.
   function automatic void owe_typed_writes(input dir_row_type row);
      int k;
      k = int'(row.typed_writes);
      if (row.op == OP_TIME) begin
         for (int p = 3; p >= 0; p--) begin
            owe_write(p, row.typed_syms[4*p +: 4], p == 2, p == 0);
         end
      end else begin
         for (int p = 0; p < k; p++) begin
            owe_write(p, row.typed_syms[4*p +: 4], 1'b0, p == k - 1);
         end
      end
   endfunction

   // Presents one request and returns at the edge where the block takes it.
   task automatic send_request(input op_mode_type op,
                               input logic signed [NUMBER_W-1:0] number,
                               input logic [TIME_W-1:0] hours,
                               input logic [TIME_W-1:0] minutes, input bit may_idle);
      int gap;
      gap = 0;
      if (may_idle && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_number    <= number;
      req_hours     <= hours;
      req_minutes   <= minutes;
      do @(posedge clock); while (busy !== 1'b0);
      if (op == OP_TIME) time_requests++;
      else integer_requests++;
   endtask

   // Lets every owed write arrive, then writes the digit count register.
   task automatic write_digit_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      digit_count_shadow = value;
      count_writes++;
      csr_write_en   <= 1'b0;
   endtask

   // Random number: mostly random-length values, some near the display limits, some corner values, some raw bits.
   function automatic logic signed [NUMBER_W-1:0] pick_number();
      int     n;
      int     len;
      longint v;
      n = visible_digits(digit_count_shadow);
      case ($urandom_range(0, 9))
         0: return NUMBER_W'($urandom());
         1: return NUMBER_W'(pow10(n) - 2 + $urandom_range(0, 2));
         2: return NUMBER_W'(-(pow10(n - 1) - 2 + $urandom_range(0, 2)));
         3: begin
            case ($urandom_range(0, 3))
               0: return 28'sh8000000;
               1: return 28'sh7FFFFFF;
               2: return -28'sd1;
               default: return 28'sd0;
            endcase
         end
         default: begin
            len = $urandom_range(1, 9);
            v   = longint'($urandom()) % pow10(len);
            if ($urandom_range(0, 1) == 1) v = -v;
            return NUMBER_W'(v);
         end
      endcase
   endfunction

   // Check every digit write against the oldest owed write.
   always @(posedge clock) begin
      rsp_type owed;
      if (!reset && rsp_strobe === 1'b1) begin
         if (writes_due.size() == 0) begin
            $error("unexpected digit write: position %0d symbol %0d",
                   rsp_digit_position, rsp_symbol);
            mismatches++;
         end else begin
            owed = writes_due.pop_front();
            writes_checked++;
            if (rsp_digit_position !== owed.digit_position) begin
               $error("digit_position: expected %0d, actual %0d",
                      owed.digit_position, rsp_digit_position);
               mismatches++;
            end
            if (rsp_symbol !== owed.symbol) begin
               $error("symbol: expected %0d, actual %0d", owed.symbol, rsp_symbol);
               mismatches++;
            end
            if (rsp_dot !== owed.dot) begin
               $error("dot: expected %0d, actual %0d", owed.dot, rsp_dot);
               mismatches++;
            end
            if (rsp_last !== owed.last) begin
               $error("last: expected %0d, actual %0d", owed.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Run limit.
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      dir_row_type                row;
      op_mode_type                op;
      logic signed [NUMBER_W-1:0] number;
      logic [TIME_W-1:0]          hours;
      logic [TIME_W-1:0]          minutes;
      int                         drain_cycles;
      clock              = 1'b0;
      reset              = 1'b1;
      start              = 1'b0;
      req_operation      = OP_INTEGER;
      req_number         = '0;
      req_hours          = '0;
      req_minutes        = '0;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      digit_count_shadow = 4'd4;
      mismatches         = 0;
      writes_checked     = 0;
      integer_requests   = 0;
      time_requests      = 0;
      count_writes       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests; the digit count changes only between settled requests.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.count != digit_count_shadow) write_digit_count(row.count);
         send_request(row.op, row.number, row.hours, row.minutes, 1'b1);
         if (row.typed_writes != 0) owe_typed_writes(row);
         else format_request(row.op, row.number, row.hours, row.minutes);
      end

      // Random requests, one digit count per phase.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_digit_count(PHASE_COUNTS[ph]);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            op      = op_mode_type'($urandom_range(0, 1));
            number  = pick_number();
            hours   = ($urandom_range(0, 99) < 70) ? TIME_W'($urandom_range(0, 23))
                                                   : TIME_W'($urandom());
            minutes = ($urandom_range(0, 99) < 70) ? TIME_W'($urandom_range(0, 59))
                                                   : TIME_W'($urandom());
            send_request(op, number, hours, minutes, ph != 0);
            format_request(op, number, hours, minutes);
         end
      end
      start <= 1'b0;

      // Let the remaining writes come out, with a bound.
      drain_cycles = 0;
      while (writes_due.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (writes_due.size() != 0) begin
         $error("%0d digit writes never arrived", writes_due.size());
         mismatches++;
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d integer and %0d time requests over %0d digit count settings,",
               integer_requests, time_requests, count_writes + 1);
      $display("and checked %0d digit writes with %0d mismatches.",
               writes_checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ssnf_pkg.sv
src/ssnf_div10.sv
src/ssnf_ctrl.sv
src/seven_segment_number_formatter.sv
verif/seven_segment_number_formatter_tb.sv
